>>> src/msc_pkg.sv
// Shared constants, register codes and the multiply-accumulate control type for the magnetometer sample correction.
package msc_pkg;

   localparam int GAIN_FRAC_BITS_DEF = 14;
   localparam int REG_W              = 48;
   localparam int SAMPLE_W           = 16;
   localparam int MAT_FRAC           = 14;

   localparam int ST_TARGET = 715;
   localparam int ST_LOW    = 500;
   localparam int ST_HIGH   = 1000;

   localparam logic [1:0] CSR_ORIENT_X = 2'd0;
   localparam logic [1:0] CSR_ORIENT_Y = 2'd1;
   localparam logic [1:0] CSR_ORIENT_Z = 2'd2;
   localparam logic [1:0] CSR_OFFSET   = 2'd3;

   localparam logic [REG_W-1:0] ORIENT_X_RESET = 48'h4000_0000_0000;
   localparam logic [REG_W-1:0] ORIENT_Y_RESET = 48'h0000_4000_0000;
   localparam logic [REG_W-1:0] ORIENT_Z_RESET = 48'h0000_0000_4000;
   localparam logic [REG_W-1:0] OFFSET_RESET   = 48'h0;

   typedef struct packed {
      logic mul_en;
      logic sel_gain;
      logic acc_en;
      logic acc_init;
   } msc_mac_ctl_type;

endpackage

>>> src/magnetometer_sample_correction.sv
// Top level: sequencer, configuration registers and gain store of the sample correction.
//
// One three-axis word is taken at a time; the block is not ready while it works on it. For a
// complete normal sample each of the three output axes needs one accumulator load, three terms
// on the one shared multiplier (coefficient times signed sample, then times gain, then
// accumulate) and one store. A self-test sample that passes the range check adds three
// divisions for the new gains on a restoring divider, one quotient bit per cycle. An
// incomplete sample returns a zero result. The result sits in an output register; a stalled
// result holds back only the next result.
module magnetometer_sample_correction #(
   parameter int GAIN_FRAC_BITS = msc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_x, raw_y, raw_z
   input  logic [1:0]  req_tuser,   // command, complete
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // field_x, field_y, field_z
   output logic [1:0]  rsp_tuser,   // updated, selftest_pass
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam int GW    = GAIN_FRAC_BITS + 2;
   localparam int NUM_W = GAIN_FRAC_BITS + 11;
   localparam logic [GW-1:0] UNITY = GW'(1) << GAIN_FRAC_BITS;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT     = 4'd1;
   localparam logic [3:0] S_MUL_RAW  = 4'd2;
   localparam logic [3:0] S_MUL_GAIN = 4'd3;
   localparam logic [3:0] S_ACC      = 4'd4;
   localparam logic [3:0] S_STORE    = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_DIV_WAIT = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic        upd_ff, upd_in;
   logic        pass_ff, pass_in;
   logic        selftest_ff, selftest_in;

   logic [47:0] orient_ff [3];
   logic [47:0] offset_ff;
   logic [GW-1:0] gain_ff [3];

   logic [15:0] raw_ff [3];
   logic [15:0] raw_in [3];
   logic signed [16:0] sraw_ff [3];
   logic signed [16:0] sraw_in [3];
   logic [15:0] res_ff [3];
   logic [15:0] res_in [3];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   msc_pkg::msc_mac_ctl_type mac_ctl;
   logic signed [15:0] mac_coef, mac_offset, mac_result;
   logic [GW-1:0]      mac_gain;

   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quot;
   logic [15:0]      abs_raw [3];
   logic             in_range;
   logic             req_fire;
   logic             set_unity;
   logic             gain_we;

   function automatic logic [15:0] lane(input logic [47:0] r, input logic [1:0] k);
      logic [15:0] v;
      case (k)
         2'd0:    v = r[47:32];
         2'd1:    v = r[31:16];
         default: v = r[15:0];
      endcase
      return v;
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      in_range = 1'b1;
      for (int i = 0; i < 3; i++) begin
         abs_raw[i] = raw_ff[i][15] ? 16'(~raw_ff[i] + 16'd1) : raw_ff[i];
         if (!(abs_raw[i] > 16'(msc_pkg::ST_LOW) && abs_raw[i] < 16'(msc_pkg::ST_HIGH))) begin
            in_range = 1'b0;
         end
      end
   end

   assign mac_coef   = lane(orient_ff[row_ff], col_ff);
   assign mac_offset = lane(offset_ff, row_ff);
   assign mac_gain   = gain_ff[col_ff];
   assign div_num    = (NUM_W'(msc_pkg::ST_TARGET) << GAIN_FRAC_BITS)
                       + NUM_W'(abs_raw[col_ff] >> 1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      upd_in       = upd_ff;
      pass_in      = pass_ff;
      selftest_in  = selftest_ff;
      raw_in       = raw_ff;
      sraw_in      = sraw_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mac_ctl      = '0;
      div_start    = 1'b0;
      set_unity    = 1'b0;
      gain_we      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               raw_in[0]   = req_tdata[15:0];
               raw_in[1]   = req_tdata[31:16];
               raw_in[2]   = req_tdata[47:32];
               sraw_in[0]  = -$signed({req_tdata[15], req_tdata[15:0]});
               sraw_in[1]  = $signed({req_tdata[31], req_tdata[31:16]});
               sraw_in[2]  = -$signed({req_tdata[47], req_tdata[47:32]});
               selftest_in = req_tuser[0];
               upd_in      = req_tuser[1];
               pass_in     = 1'b0;
               row_in      = 2'd0;
               if (req_tuser[1]) begin
                  set_unity = req_tuser[0];
                  state_in  = S_INIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INIT: begin
            mac_ctl.acc_init = 1'b1;
            col_in           = 2'd0;
            state_in         = S_MUL_RAW;
         end
         S_MUL_RAW: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = S_MUL_GAIN;
         end
         S_MUL_GAIN: begin
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.sel_gain = 1'b1;
            state_in         = S_ACC;
         end
         S_ACC: begin
            mac_ctl.acc_en = 1'b1;
            if (col_ff == 2'd2) begin
               state_in = S_STORE;
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = S_MUL_RAW;
            end
         end
         S_STORE: begin
            res_in[row_ff] = mac_result;
            if (row_ff == 2'd2) begin
               col_in = 2'd0;
               if (selftest_ff && in_range) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = S_INIT;
            end
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               gain_we = 1'b1;
               if (col_ff == 2'd2) begin
                  pass_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  col_in   = col_ff + 2'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = upd_ff ? {res_ff[2], res_ff[1], res_ff[0]} : '0;
               rsp_user_in  = {pass_ff, upd_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         upd_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         selftest_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         orient_ff[0] <= msc_pkg::ORIENT_X_RESET;
         orient_ff[1] <= msc_pkg::ORIENT_Y_RESET;
         orient_ff[2] <= msc_pkg::ORIENT_Z_RESET;
         offset_ff    <= msc_pkg::OFFSET_RESET;
         for (int i = 0; i < 3; i++) begin
            gain_ff[i] <= UNITY;
         end
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         upd_ff       <= upd_in;
         pass_ff      <= pass_in;
         selftest_ff  <= selftest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               msc_pkg::CSR_ORIENT_X: orient_ff[0] <= csr_data;
               msc_pkg::CSR_ORIENT_Y: orient_ff[1] <= csr_data;
               msc_pkg::CSR_ORIENT_Z: orient_ff[2] <= csr_data;
               msc_pkg::CSR_OFFSET:   offset_ff    <= csr_data;
               default: ;
            endcase
         end
         if (set_unity) begin
            for (int i = 0; i < 3; i++) begin
               gain_ff[i] <= UNITY;
            end
         end else if (gain_we) begin
            gain_ff[col_ff] <= div_quot[GW-1:0];
         end
      end
      raw_ff      <= raw_in;
      sraw_ff     <= sraw_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   msc_mac #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .coef   (mac_coef),
      .sraw   (sraw_ff[col_ff]),
      .gain   (mac_gain),
      .offset (mac_offset),
      .result (mac_result)
   );

   msc_divider #(
      .NUM_W(NUM_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (abs_raw[col_ff]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input accepted while a word is in progress");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_selftest_unity: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser[0] && req_tuser[1] |=>
         gain_ff[0] == UNITY && gain_ff[1] == UNITY && gain_ff[2] == UNITY)
      else $error("gains not set to unity on a self-test word");

   a_stale_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("word without update carries data");

   a_pass_needs_selftest: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> selftest_ff && upd_ff)
      else $error("gain division on a word that is not a complete self-test");

endmodule

>>> src/msc_mac.sv
// Shared multiplier and accumulator with rounding and 16-bit saturation.
module msc_mac #(
   parameter int GAIN_FRAC_BITS = msc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  msc_pkg::msc_mac_ctl_type     ctl,
   input  logic signed [15:0]           coef,
   input  logic signed [16:0]           sraw,
   input  logic [GAIN_FRAC_BITS+1:0]    gain,
   input  logic signed [15:0]           offset,
   output logic signed [15:0]           result
);

   localparam int GW       = GAIN_FRAC_BITS + 2;
   localparam int AW       = 33;
   localparam int BW       = (GW + 1 > 17) ? GW + 1 : 17;
   localparam int PW       = AW + BW;
   localparam int ACC_W    = PW + 2;
   localparam int SUM_FRAC = GAIN_FRAC_BITS + msc_pkg::MAT_FRAC;
   localparam int HW       = ACC_W - SUM_FRAC;

   logic signed [AW-1:0]    mul_a;
   logic signed [BW-1:0]    mul_b;
   logic signed [PW-1:0]    prod_in, prod_ff;
   logic signed [ACC_W-1:0] acc_in, acc_ff;
   logic        [HW-1:0]    hi;
   logic                    fits;

   always_comb begin
      if (ctl.sel_gain) begin
         mul_a = prod_ff[AW-1:0];
         mul_b = BW'($signed({1'b0, gain}));
      end else begin
         mul_a = AW'(coef);
         mul_b = BW'(sraw);
      end
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      if (ctl.acc_init) begin
         acc_in = {{(HW-16){offset[15]}}, offset, 1'b1, {(SUM_FRAC-1){1'b0}}};
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_init || ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      hi   = acc_ff[ACC_W-1:SUM_FRAC];
      fits = (&hi[HW-1:15]) || !(|hi[HW-1:15]);
      if (fits) begin
         result = hi[15:0];
      end else if (hi[HW-1]) begin
         result = 16'sh8000;
      end else begin
         result = 16'sh7fff;
      end
   end

endmodule

>>> src/msc_divider.sv
// Restoring divider, one quotient bit per cycle.
module msc_divider #(
   parameter int NUM_W = msc_pkg::GAIN_FRAC_BITS_DEF + 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [15:0]      den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [16:0]      trial;
   logic             ge;

   always_comb begin
      trial    = {rem_ff, q_ff[NUM_W-1]};
      ge       = trial >= {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         den_in   = den;
         q_in     = num;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = 16'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[15:0];
         end
         q_in     = {q_ff[NUM_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
